>>> rtl/core/zpic_pkg.sv
// Shared types and constants of the zero-padded image convolver.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package zpic_pkg;

    localparam int MAX_WIDTH      = 1024;
    localparam int COL_W          = $clog2(MAX_WIDTH);
    localparam int KMAX           = 7;
    localparam int KMAX_W         = 3;
    localparam int COEF_FRAC_BITS = 8;
    localparam int PIX_MAX        = 255;
    localparam int QDEPTH         = 4;
    localparam int QPTR_W         = $clog2(QDEPTH);
    localparam int MAX_RES        = 4;
    localparam int PROD_W         = 25;
    localparam int ACC_W          = 32;

    localparam logic [1:0] FUNC_COEF  = 2'd0;
    localparam logic [1:0] FUNC_PIXEL = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    localparam logic [2:0] CFG_IMG_W = 3'd0;
    localparam logic [2:0] CFG_IMG_H = 3'd1;
    localparam logic [2:0] CFG_KER_W = 3'd2;
    localparam logic [2:0] CFG_KER_H = 3'd3;

    typedef struct packed {
        logic [COL_W:0]  width;
        logic [15:0]     height;
        logic [KMAX_W-1:0] kw;
        logic [KMAX_W-1:0] kh;
    } t_geom;

    typedef struct packed {
        logic                          is_coef;
        logic [KMAX_W-1:0]             coef_row;
        logic [KMAX_W-1:0]             coef_col;
        logic signed [15:0]            coef_val;
        logic [7:0]                    pix;
        logic [COL_W-1:0]              wr_col;
        logic [KMAX_W-1:0]             wr_slot;
        logic [COL_W:0]                out_col;
        logic [2:0]                    n_out;
        logic                          eof;
        logic [KMAX-1:0]               row_ok;
        logic [KMAX-1:0][KMAX_W-1:0]   lane_slot;
    } t_cmd;

    // Kernel row of a flat coefficient index: count of row starts after the first at or below it.
    function automatic logic [KMAX_W-1:0] kernel_row(input logic [5:0] idx);
        logic [KMAX_W-1:0] row;
        row = '0;
        for (int k = 1; k < KMAX; k++) begin
            if (idx >= 6'(k * KMAX)) begin
                row = row + 1'b1;
            end
        end
        return row;
    endfunction

endpackage

>>> rtl/core/zpic_front.sv
// Front end: accepts input transactions, tracks the raster position and
// turns each item into a command for the back end. Uses zpic_pkg.
`timescale 1ns / 1ps

module zpic_front import zpic_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_geom              i_geom,
    input  logic               i_accept,
    input  logic [1:0]         i_func,
    input  logic [5:0]         i_coef_index,
    input  logic signed [15:0] i_coef_value,
    input  logic [7:0]         i_pixel_in,
    output logic               o_push,
    output t_cmd               o_cmd
);

    logic [COL_W-1:0]  r_ic;
    logic [16:0]       r_ir;
    logic [COL_W:0]    r_oc;
    logic [KMAX_W-1:0] r_slot;

    logic [KMAX_W-1:0] w_ad, w_ar;
    logic [COL_W:0]    w_ic_ext, w_limit, w_diff, w_lastcol;
    logic              w_rowend, w_inrows, w_have, w_eof, w_restart, w_is_pix;
    logic [15:0]       w_orow;
    logic [2:0]        w_n;
    logic [16:0]       w_ir_next;
    logic [KMAX_W-1:0] w_krow;

    assign w_ad     = KMAX_W'(i_geom.kh - 1'b1 - (i_geom.kh >> 1));
    assign w_ar     = KMAX_W'(i_geom.kw - 1'b1 - (i_geom.kw >> 1));
    assign w_ic_ext = {1'b0, r_ic};
    assign w_rowend = (w_ic_ext + 1'b1) >= i_geom.width;
    assign w_inrows = (r_ir >= 17'(w_ad)) && ((r_ir - 17'(w_ad)) < {1'b0, i_geom.height});
    assign w_orow   = 16'(r_ir - 17'(w_ad));
    assign w_have   = w_rowend || (w_ic_ext >= (COL_W + 1)'(w_ar));
    assign w_limit  = w_rowend ? i_geom.width - 1'b1 : w_ic_ext - (COL_W + 1)'(w_ar);
    assign w_diff   = w_limit - r_oc;

    always_comb begin
        w_n = 3'd0;
        if (w_inrows && w_have && (r_oc <= w_limit)) begin
            w_n = (w_diff >= (COL_W + 1)'(MAX_RES - 1)) ? 3'(MAX_RES) : 3'(w_diff) + 3'd1;
        end
    end

    assign w_lastcol = r_oc + (COL_W + 1)'(w_n) - 1'b1;
    assign w_eof     = (w_n != 3'd0) && (w_orow == i_geom.height - 1'b1)
                       && (w_lastcol == i_geom.width - 1'b1);
    assign w_ir_next = w_rowend ? r_ir + 1'b1 : r_ir;
    assign w_restart = w_eof || (w_ir_next >= ({1'b0, i_geom.height} + 17'(w_ad)));
    assign w_is_pix  = (i_func == FUNC_PIXEL) || (i_func == FUNC_FLUSH);
    assign w_krow    = kernel_row(i_coef_index);

    always_comb begin
        logic [17:0] y;
        logic [4:0]  t;
        o_cmd          = '0;
        o_cmd.is_coef  = (i_func == FUNC_COEF);
        o_cmd.coef_row = w_krow;
        o_cmd.coef_col = KMAX_W'(i_coef_index - 6'(w_krow) * 6'(KMAX));
        o_cmd.coef_val = i_coef_value;
        o_cmd.pix      = (i_func == FUNC_PIXEL) ? i_pixel_in : 8'd0;
        o_cmd.wr_col   = r_ic;
        o_cmd.wr_slot  = r_slot;
        o_cmd.out_col  = r_oc;
        o_cmd.n_out    = w_n;
        o_cmd.eof      = w_eof;
        for (int kr = 0; kr < KMAX; kr++) begin
            y = 18'(r_ir) + 18'(kr);
            o_cmd.row_ok[kr] = (KMAX_W'(kr) < i_geom.kh)
                               && (y >= 18'(i_geom.kh) - 18'd1)
                               && (y < 18'(i_geom.height) + 18'(i_geom.kh) - 18'd1);
            t = 5'(r_slot) + 5'(KMAX) - 5'(i_geom.kh - 1'b1) + 5'(kr);
            if (t >= 5'(2 * KMAX)) begin
                t = t - 5'(2 * KMAX);
            end else if (t >= 5'(KMAX)) begin
                t = t - 5'(KMAX);
            end
            o_cmd.lane_slot[kr] = KMAX_W'(t);
        end
    end

    assign o_push = i_accept && (w_is_pix || ((i_func == FUNC_COEF)
                    && (i_coef_index < 6'(KMAX * KMAX))));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic   <= '0;
            r_ir   <= '0;
            r_oc   <= '0;
            r_slot <= '0;
        end else if (i_accept && w_is_pix) begin
            if (w_restart) begin
                r_ic   <= '0;
                r_ir   <= '0;
                r_oc   <= '0;
                r_slot <= '0;
            end else if (w_rowend) begin
                r_ic   <= '0;
                r_ir   <= w_ir_next;
                r_oc   <= '0;
                r_slot <= (r_slot == KMAX_W'(KMAX - 1)) ? '0 : r_slot + 1'b1;
            end else begin
                r_ic <= r_ic + 1'b1;
                r_oc <= r_oc + (COL_W + 1)'(w_n);
            end
        end
    end

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < KMAX_W'(KMAX))
        else $error("line slot out of range");

    a_slot_tracks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ir == 17'd0) |-> (r_slot == '0))
        else $error("line slot out of step with input row");

    a_out_behind_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oc <= w_ic_ext + 1'b1)
        else $error("output column ran ahead of input column");

endmodule

>>> rtl/core/zpic_queue.sv
// Short command queue between front and back end.
// Holds t_cmd entries from zpic_pkg.
`timescale 1ns / 1ps

module zpic_queue import zpic_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_count;

    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_count <= r_count + (QPTR_W + 1)'(i_push) - (QPTR_W + 1)'(i_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty queue");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance");

endmodule

>>> rtl/core/zpic_back.sv
// Back end: line and coefficient stores, the column-serial multiply-accumulate
// pipeline and the output register. Uses zpic_pkg.
`timescale 1ns / 1ps

module zpic_back import zpic_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_geom      i_geom,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output logic [7:0] o_pixel_out,
    output logic       o_last_in_run,
    output logic       o_end_of_frame
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state, n_state;
    t_cmd   r_cmd;

    logic [7:0]         r_line [KMAX][MAX_WIDTH];
    logic signed [15:0] r_coef [KMAX][KMAX];

    logic [KMAX_W-1:0]  r_kc;
    logic [COL_W:0]     r_col;
    logic [1:0]         r_j;
    logic [KMAX_W-1:0]  w_pw;
    logic [COL_W+2:0]   w_x;
    logic               w_xok, w_issue, w_last_kc, w_load, w_last_out;

    logic [7:0]               r_a_rd   [KMAX];
    logic signed [15:0]       r_a_coef [KMAX];
    logic                     r_a_vld, r_a_first, r_a_last, r_a_xok;
    logic signed [PROD_W-1:0] r_b_prod [KMAX];
    logic                     r_b_vld, r_b_first, r_b_last;
    logic signed [ACC_W-1:0]  r_c_sum, w_sum;
    logic                     r_c_vld, r_c_first, r_c_last;
    logic signed [ACC_W-1:0]  r_acc, w_shift;
    logic                     r_done;
    logic [7:0]               w_clip;

    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign w_issue   = (r_state == S_ISSUE);
    assign w_last_kc = (r_kc == i_geom.kw - 1'b1);
    assign w_pw      = i_geom.kw >> 1;
    assign w_x       = {2'b00, r_col} + (COL_W + 3)'(r_kc) - (COL_W + 3)'(w_pw);
    assign w_xok     = !w_x[COL_W+2] && (w_x < {2'b00, i_geom.width});
    assign w_load    = (r_state == S_OUT) && (!o_out_valid || !i_out_stall);
    assign w_last_out = ({1'b0, r_j} + 3'd1 == r_cmd.n_out);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && !i_q_cmd.is_coef && (i_q_cmd.n_out != 3'd0)) begin
                    n_state = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (w_last_kc) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (r_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_load) begin
                    n_state = w_last_out ? S_IDLE : S_ISSUE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer counters: kernel column within an output and output within a command.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
            r_col <= i_q_cmd.out_col;
            r_j   <= '0;
            r_kc  <= '0;
        end else if (w_issue) begin
            r_kc <= w_last_kc ? '0 : r_kc + 1'b1;
        end else if (w_load) begin
            r_col <= r_col + 1'b1;
            r_j   <= r_j + 1'b1;
        end
    end

    // Stores: one line bank per row slot, one coefficient bank per kernel row.
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < KMAX; b++) begin
            if (o_q_pop && !i_q_cmd.is_coef && (i_q_cmd.wr_slot == KMAX_W'(b))) begin
                r_line[b][i_q_cmd.wr_col] <= i_q_cmd.pix;
            end
            r_a_rd[b] <= r_line[b][w_x[COL_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < KMAX; b++) begin
            if (o_q_pop && i_q_cmd.is_coef && (i_q_cmd.coef_row == KMAX_W'(b))) begin
                r_coef[b][i_q_cmd.coef_col] <= i_q_cmd.coef_val;
            end
            r_a_coef[b] <= r_coef[b][r_kc];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_first <= (r_kc == '0);
        r_a_last  <= w_last_kc;
        r_a_xok   <= w_xok;
        for (int kr = 0; kr < KMAX; kr++) begin
            if (r_a_xok && r_cmd.row_ok[kr]) begin
                r_b_prod[kr] <= $signed({1'b0, r_a_rd[r_cmd.lane_slot[kr]]}) * r_a_coef[kr];
            end else begin
                r_b_prod[kr] <= '0;
            end
        end
        r_b_first <= r_a_first;
        r_b_last  <= r_a_last;
        r_c_sum   <= w_sum;
        r_c_first <= r_b_first;
        r_c_last  <= r_b_last;
        if (r_c_vld) begin
            r_acc <= r_c_first ? r_c_sum : r_acc + r_c_sum;
        end
    end

    always_comb begin
        w_sum = '0;
        for (int kr = 0; kr < KMAX; kr++) begin
            w_sum = w_sum + ACC_W'(r_b_prod[kr]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_a_vld <= w_issue;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_done  <= r_c_vld && r_c_last;
        end
    end

    // Floor to integer, then clip into 0..255.
    assign w_shift = r_acc >>> COEF_FRAC_BITS;
    always_comb begin
        if (r_acc < 0) begin
            w_clip = 8'd0;
        end else if (w_shift > ACC_W'(PIX_MAX)) begin
            w_clip = 8'(PIX_MAX);
        end else begin
            w_clip = w_shift[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_pixel_out    <= w_clip;
            o_last_in_run  <= w_last_out;
            o_end_of_frame <= w_last_out && r_cmd.eof;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    a_pipe_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld || r_b_vld || r_c_vld) |-> (r_state == S_ISSUE || r_state == S_WAIT))
        else $error("accumulate pipeline active outside an output");

    a_result_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result appeared without an output step");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_WAIT))
        else $error("sum finished outside the wait step");

endmodule

>>> rtl/core/zero_padded_image_convolver.sv
// Top level of the zero-padded image convolver: configuration registers and
// the front end, command queue and back end. Uses zpic_pkg and all zpic_* modules.
`timescale 1ns / 1ps

// Streaming 2D convolution of one 8-bit channel with a signed kernel of up to
// 7 by 7 coefficients (8 fractional bits), zero padding around the image.
// Input channel (i_in_valid / o_in_stall): each transaction is a coefficient
// write, an image pixel in raster order, or a flush standing for a bottom
// padding position. Output channel (o_out_valid / i_out_stall): filtered
// pixels, floored and clipped to 0..255; the last result caused by an item
// carries o_last_in_run and the bottom-right pixel carries o_end_of_frame.
// Configuration (i_cfg_valid / o_cfg_ready, always ready) sets image width,
// image height, kernel width and kernel height; write it only while idle.
// Each output pixel is a multiply-accumulate over the kernel columns, one kernel
// column of seven rows per cycle, through the read, product and sum registers
// and the accumulator, then the output register; an item can release up to
// four pixels, and the back end pops the next command only once it is done.
// The front end keeps accepting while the four-entry queue has room.
// Reset clears counters, queue and output valid; registers return to width
// 1024, height 1, 3 by 3 kernel. Coefficients must be written before use.
// When the receiver stalls, the output holds and the back end waits.
module zero_padded_image_convolver import zpic_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic [5:0]         i_coef_index,
    input  logic signed [15:0] i_coef_value,
    input  logic [7:0]         i_pixel_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_pixel_out,
    output logic               o_last_in_run,
    output logic               o_end_of_frame,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    t_geom r_geom;
    t_cmd  w_front_cmd, w_head_cmd;
    logic  w_accept, w_push, w_full, w_q_valid, w_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_full;
    assign w_accept    = i_in_valid && !w_full;

    // Registers are stored already forced into their legal ranges; width and kernel sizes use only the low data bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.width  <= (COL_W + 1)'(MAX_WIDTH);
            r_geom.height <= 16'd1;
            r_geom.kw     <= 3'd3;
            r_geom.kh     <= 3'd3;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IMG_W: begin
                    if (i_cfg_data[10:0] == 11'd0) begin
                        r_geom.width <= (COL_W + 1)'(1);
                    end else if (i_cfg_data[10:0] > 11'(MAX_WIDTH)) begin
                        r_geom.width <= (COL_W + 1)'(MAX_WIDTH);
                    end else begin
                        r_geom.width <= (COL_W + 1)'(i_cfg_data[10:0]);
                    end
                end
                CFG_IMG_H: begin
                    r_geom.height <= (i_cfg_data == 16'd0) ? 16'd1 : i_cfg_data;
                end
                CFG_KER_W: begin
                    r_geom.kw <= (i_cfg_data[2:0] == 3'd0) ? 3'd1 : i_cfg_data[2:0];
                end
                CFG_KER_H: begin
                    r_geom.kh <= (i_cfg_data[2:0] == 3'd0) ? 3'd1 : i_cfg_data[2:0];
                end
                default: begin
                end
            endcase
        end
    end

    zpic_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (r_geom),
        .i_accept     (w_accept),
        .i_func       (i_func),
        .i_coef_index (i_coef_index),
        .i_coef_value (i_coef_value),
        .i_pixel_in   (i_pixel_in),
        .o_push       (w_push),
        .o_cmd        (w_front_cmd)
    );

    zpic_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_head_cmd)
    );

    zpic_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_geom         (r_geom),
        .i_q_valid      (w_q_valid),
        .i_q_cmd        (w_head_cmd),
        .o_q_pop        (w_pop),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_pixel_out    (o_pixel_out),
        .o_last_in_run  (o_last_in_run),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule
